[sv/cwrt_pkg.sv]
// ----------------------------------------------------------------------------
// cwrt_pkg: shared types and constants
// register indexes, event codes, reset values, sequencer states and the
// control bundle that drives the shared multiply-accumulate unit
// ----------------------------------------------------------------------------
package cwrt_pkg;

  // initial window, threshold (segments) and timeout (ms)
  localparam int INIT_WINDOW     = 10;
  localparam int INIT_THRESHOLD  = 64;
  localparam int INIT_TIMEOUT_MS = 1000;

  localparam logic [31:0] WINDOW_RESET    = 32'(INIT_WINDOW) << 16;
  localparam logic [31:0] THRESHOLD_RESET = 32'(INIT_THRESHOLD) << 16;
  localparam logic [23:0] TIMEOUT_RESET   = 24'(INIT_TIMEOUT_MS << 8);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SRTT_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RTTVAR_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RTO_FLOOR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RTO_CEILING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FLOOR = 3'd4;
  localparam int CFG_DATA_W = 24;

  // configuration reset values
  localparam logic [7:0]  SRTT_GAIN_RESET    = 8'd32;
  localparam logic [7:0]  RTTVAR_GAIN_RESET  = 8'd64;
  localparam logic [23:0] RTO_FLOOR_RESET    = 24'd51200;
  localparam logic [23:0] RTO_CEILING_RESET  = 24'd15360000;
  localparam logic [15:0] WINDOW_FLOOR_RESET = 16'd2;

  // event codes
  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_LOSS = 2'd2;

  // gain arithmetic: coefficients are n/256
  localparam logic [8:0] GAIN_ONE = 9'd256;

  // reciprocal divider: 2^32 / divisor, two quotient bits a step
  localparam int DIV_BITS   = 34;
  localparam int DIV_STEPS  = DIV_BITS / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam logic [DIV_BITS-1:0] DIV_DIVIDEND = DIV_BITS'(64'h1_0000_0000);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MAC0,
    S_MAC1,
    S_MAC2,
    S_MAC3,
    S_MAC4,
    S_RTO,
    S_DIV,
    S_GROW,
    S_OUT
  } state_t;

  typedef struct packed {
    logic        en;
    logic        load;
    logic [8:0]  coef;
    logic [23:0] data;
  } mac_ctrl_t;

endpackage

[sv/cwrt_mac.sv]
// ----------------------------------------------------------------------------
// cwrt_mac: shared multiply-accumulate unit
// 9 x 24 bit product added into a 32 bit accumulator, or loaded into it
// ----------------------------------------------------------------------------
module cwrt_mac (
  input  logic              clk,
  input  cwrt_pkg::mac_ctrl_t ctrl,
  output logic [31:0]       acc
);
  import cwrt_pkg::*;

  logic [32:0] product;
  logic [32:0] sum;

  assign product = 33'(ctrl.coef) * 33'(ctrl.data);
  // two weighted terms with weights summing to 256 never pass 32 bits
  assign sum     = (ctrl.load ? 33'd0 : {1'b0, acc}) + product;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= sum[31:0];
    end
  end

endmodule

[sv/cwrt_div.sv]
// ----------------------------------------------------------------------------
// cwrt_div: iterative reciprocal divider
// restoring division of 2^32 by a 32 bit divisor, two quotient bits a cycle
// ----------------------------------------------------------------------------
module cwrt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [32:0] quotient
);
  import cwrt_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          rem;
  logic [31:0]          dsr;
  logic [DIV_BITS-1:0]  dvd;
  logic [DIV_BITS-1:0]  quo;

  logic [32:0] part1;
  logic [32:0] part2;
  logic        qbit1;
  logic        qbit2;
  logic [31:0] rem1;
  logic [31:0] rem2;
  logic [32:0] diff1;
  logic [32:0] diff2;

  always_comb begin
    part1 = {rem, dvd[DIV_BITS-1]};
    diff1 = part1 - {1'b0, dsr};
    qbit1 = (part1 >= {1'b0, dsr});
    rem1  = qbit1 ? diff1[31:0] : part1[31:0];
    part2 = {rem1, dvd[DIV_BITS-2]};
    diff2 = part2 - {1'b0, dsr};
    qbit2 = (part2 >= {1'b0, dsr});
    rem2  = qbit2 ? diff2[31:0] : part2[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      dvd <= DIV_DIVIDEND;
      quo <= '0;
    end else if (busy) begin
      rem <= rem2;
      dvd <= {dvd[DIV_BITS-3:0], 2'b00};
      quo <= {quo[DIV_BITS-3:0], qbit1, qbit2};
    end
  end

  assign quotient = quo[32:0];

endmodule

[sv/congestion_window_rto_tracker.sv]
// ----------------------------------------------------------------------------
// congestion_window_rto_tracker: reno window and rto estimator
// send, ack and loss events update window, threshold, in-flight count and the
// smoothed rtt estimator; each item returns one result with the new values
// ----------------------------------------------------------------------------
// sequence: a send, loss or unused event goes from exec straight to the output state;
//   an ack runs the mac states (skipped on the first sample), then rto, div, grow, out;
//   in avoidance div waits on the 17 radix-4 steps of the reciprocal divider
// the block holds one item at a time; the next item is taken the cycle
//   after the result is loaded into the output register, while it still waits
// reset: synchronous, active high; loads the initial state and register defaults
module congestion_window_rto_tracker (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_wr_en,
  input  logic [cwrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cwrt_pkg::CFG_DATA_W-1:0] cfg_data,
  // event items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [23:0]                   rtt_sample_q8,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          can_send,
  output logic [15:0]                   window_segments,
  output logic [15:0]                   outstanding,
  output logic [23:0]                   timeout_q8,
  output logic [23:0]                   smoothed_rtt_q8,
  output logic                          avoidance_phase
);
  import cwrt_pkg::*;

  // configuration registers
  logic [7:0]  srtt_gain;
  logic [7:0]  rttvar_gain;
  logic [23:0] rto_floor;
  logic [23:0] rto_ceiling;
  logic [15:0] window_floor;

  // tracker state
  logic [31:0] window_q16;
  logic [31:0] threshold_q16;
  logic [15:0] flight_count;
  logic [23:0] srtt;
  logic [23:0] rttvar;
  logic [23:0] rto;
  logic        sample_seen;
  logic        phase;

  // captured item and scratch
  logic [1:0]  cmd_reg;
  logic [23:0] rtt_reg;
  logic [23:0] diff;

  state_t state;
  state_t state_next;

  // control decode
  mac_ctrl_t mac_ctrl;
  logic      div_start;
  logic      load_out;
  logic      out_free;

  logic [31:0] mac_acc;
  logic        div_busy;
  logic [32:0] div_quo;

  // datapath combinational terms
  logic [26:0] rto_sum;
  logic [26:0] rto_low;
  logic [26:0] rto_clamped;
  logic [32:0] grow_inc;
  logic [33:0] grow_sum;
  logic [31:0] grow_win;
  logic [31:0] loss_floor;
  logic [31:0] loss_half;

  assign out_free = !out_valid || out_ready;

  // ---------------------------------------------------------------------------
  // shared units
  // ---------------------------------------------------------------------------
  cwrt_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .acc  (mac_acc)
  );

  cwrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (window_q16),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_reg == CMD_ACK) begin
          // first sample seeds the estimator directly
          state_next = sample_seen ? S_MAC0 : S_RTO;
        end else begin
          state_next = S_OUT;
        end
      end
      S_MAC0: state_next = S_MAC1;
      S_MAC1: state_next = S_MAC2;
      S_MAC2: state_next = S_MAC3;
      S_MAC3: state_next = S_MAC4;
      S_MAC4: state_next = S_RTO;
      S_RTO:  state_next = S_DIV;
      S_DIV: begin
        if (!div_busy) begin
          state_next = S_GROW;
        end
      end
      S_GROW: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready      = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    mac_ctrl.en   = 1'b0;
    mac_ctrl.load = 1'b0;
    mac_ctrl.coef = '0;
    mac_ctrl.data = '0;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_EXEC: begin
        // reciprocal only needed in avoidance with a nonzero window
        div_start = (cmd_reg == CMD_ACK) && phase && (window_q16 != '0);
      end
      S_MAC0: begin
        mac_ctrl.en   = 1'b1;
        mac_ctrl.load = 1'b1;
        mac_ctrl.coef = GAIN_ONE - {1'b0, rttvar_gain};
        mac_ctrl.data = rttvar;
      end
      S_MAC1: begin
        mac_ctrl.en   = 1'b1;
        mac_ctrl.coef = {1'b0, rttvar_gain};
        mac_ctrl.data = diff;
      end
      S_MAC2: begin
        mac_ctrl.en   = 1'b1;
        mac_ctrl.load = 1'b1;
        mac_ctrl.coef = GAIN_ONE - {1'b0, srtt_gain};
        mac_ctrl.data = srtt;
      end
      S_MAC3: begin
        mac_ctrl.en   = 1'b1;
        mac_ctrl.coef = {1'b0, srtt_gain};
        mac_ctrl.data = rtt_reg;
      end
      S_OUT: load_out = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration port, writes beyond the list are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      srtt_gain    <= SRTT_GAIN_RESET;
      rttvar_gain  <= RTTVAR_GAIN_RESET;
      rto_floor    <= RTO_FLOOR_RESET;
      rto_ceiling  <= RTO_CEILING_RESET;
      window_floor <= WINDOW_FLOOR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SRTT_GAIN:    srtt_gain    <= cfg_data[7:0];
        REG_RTTVAR_GAIN:  rttvar_gain  <= cfg_data[7:0];
        REG_RTO_FLOOR:    rto_floor    <= cfg_data[23:0];
        REG_RTO_CEILING:  rto_ceiling  <= cfg_data[23:0];
        REG_WINDOW_FLOOR: window_floor <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // datapath terms
  // ---------------------------------------------------------------------------
  always_comb begin
    // rto = srtt + 4 * rttvar, floor first, ceiling last so it wins
    rto_sum     = {3'b000, srtt} + {1'b0, rttvar, 2'b00};
    rto_low     = (rto_sum < {3'b000, rto_floor}) ? {3'b000, rto_floor} : rto_sum;
    rto_clamped = (rto_low > {3'b000, rto_ceiling}) ? {3'b000, rto_ceiling} : rto_low;

    // window growth: one segment in slow start, reciprocal in avoidance
    if (!phase) begin
      grow_inc = 33'h0_0001_0000;
    end else if (window_q16 == '0) begin
      grow_inc = 33'h1_0000_0000;
    end else begin
      grow_inc = div_quo;
    end
    grow_sum = {2'b00, window_q16} + {1'b0, grow_inc};
    grow_win = (grow_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : grow_sum[31:0];

    // loss: threshold is half the window, never below the floor
    loss_floor = {window_floor, 16'h0000};
    loss_half  = {1'b0, window_q16[31:1]};
  end

  // ---------------------------------------------------------------------------
  // tracker state updates
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      window_q16    <= WINDOW_RESET;
      threshold_q16 <= THRESHOLD_RESET;
      flight_count  <= '0;
      srtt          <= '0;
      rttvar        <= '0;
      rto           <= TIMEOUT_RESET;
      sample_seen   <= 1'b0;
      phase         <= 1'b0;
    end else begin
      case (state)
        S_EXEC: begin
          case (cmd_reg)
            CMD_SEND: begin
              if (flight_count != 16'hFFFF) begin
                flight_count <= flight_count + 16'd1;
              end
            end
            CMD_ACK: begin
              if (flight_count != '0) begin
                flight_count <= flight_count - 16'd1;
              end
              if (!sample_seen) begin
                srtt        <= rtt_reg;
                rttvar      <= {1'b0, rtt_reg[23:1]};
                sample_seen <= 1'b1;
              end
            end
            CMD_LOSS: begin
              threshold_q16 <= (loss_half < loss_floor) ? loss_floor : loss_half;
              window_q16    <= loss_floor;
              phase         <= 1'b0;
            end
            default: begin
              // unused event: nothing changes
            end
          endcase
        end
        S_MAC2: rttvar <= mac_acc[31:8];
        S_MAC4: srtt   <= mac_acc[31:8];
        S_RTO:  rto    <= rto_clamped[23:0];
        S_GROW: begin
          window_q16 <= grow_win;
          if (!phase && (grow_win >= threshold_q16)) begin
            phase <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // captured item and the |srtt - rtt| term for the variance update
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_reg <= cmd;
      rtt_reg <= rtt_sample_q8;
    end
    if (state == S_EXEC) begin
      diff <= (srtt >= rtt_reg) ? (srtt - rtt_reg) : (rtt_reg - srtt);
    end
  end

  // ---------------------------------------------------------------------------
  // output register, frees the input side while a result waits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      can_send        <= (flight_count < window_q16[31:16]);
      window_segments <= window_q16[31:16];
      outstanding     <= flight_count;
      timeout_q8      <= rto;
      smoothed_rtt_q8 <= srtt;
      avoidance_phase <= phase;
    end
  end

endmodule

[sv/cwrt_checker.sv]
// ----------------------------------------------------------------------------
// cwrt_checker: port-level checks for the tracker
// watches the handshakes and result fields over time
// ----------------------------------------------------------------------------
module cwrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        can_send,
  input logic [15:0] window_segments,
  input logic [15:0] outstanding
);

  // one item at a time: the block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again straight after an accepted item");

  // a waiting result is not withdrawn
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  // can_send agrees with the reported counts
  a_can_send: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (can_send == (outstanding < window_segments)))
    else $error("can_send disagrees with outstanding and window");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind congestion_window_rto_tracker cwrt_checker u_cwrt_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .can_send        (can_send),
  .window_segments (window_segments),
  .outstanding     (outstanding)
);

[bench/tb_congestion_window_rto_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_congestion_window_rto_tracker: self-checking bench for the reno tracker
// a directed table after reset, then random send, ack and loss traffic under
// several register settings, with random stalls on both handshakes; every
// result item is checked against the table or a cycle-free model of window,
// threshold, in-flight count and the rtt estimator
// ----------------------------------------------------------------------------
module tb_congestion_window_rto_tracker;
  import cwrt_pkg::*;

  // the fourth event code has no action in the block
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // one result item, fields in port order
  typedef struct packed {
    logic        can_send;
    logic [15:0] window_segments;
    logic [15:0] outstanding;
    logic [23:0] timeout_q8;
    logic [23:0] smoothed_rtt_q8;
    logic        avoidance_phase;
  } tracker_result_t;

  // one row of the directed table; want is only used where typed is set
  typedef struct packed {
    logic [1:0]      op;
    logic [23:0]     sample;
    logic            typed;
    tracker_result_t want;
  } tracker_step_t;

  // opening table, reset values apply. the first rows have results that can be
  // worked out by hand, the rest go through the model
  localparam tracker_step_t DIRECTED_STEPS [24] = '{
    // send straight after reset
    '{CMD_SEND,   24'h000000, 1'b1, '{1'b1, 16'd10, 16'd1, 24'd256000, 24'd0, 1'b0}},
    // unused event code changes nothing
    '{CMD_UNUSED, 24'hFFFFFF, 1'b1, '{1'b1, 16'd10, 16'd1, 24'd256000, 24'd0, 1'b0}},
    // loss drops the window to the floor of two segments
    '{CMD_LOSS,   24'h000000, 1'b1, '{1'b1, 16'd2, 16'd1, 24'd256000, 24'd0, 1'b0}},
    // first sample of zero seeds the estimator, timeout pinned to its floor
    '{CMD_ACK,    24'h000000, 1'b1, '{1'b1, 16'd3, 16'd0, 24'd51200, 24'd0, 1'b0}},
    '{CMD_ACK,    24'hFFFFFF, 1'b0, '0},
    // window reaches threshold, switch to avoidance
    '{CMD_ACK,    24'h000000, 1'b0, '0},
    '{CMD_ACK,    24'd256000, 1'b0, '0},
    '{CMD_SEND,   24'h000000, 1'b0, '0},
    '{CMD_SEND,   24'hFFFFFF, 1'b0, '0},
    '{CMD_SEND,   24'h123456, 1'b0, '0},
    '{CMD_SEND,   24'h000000, 1'b0, '0},
    '{CMD_ACK,    24'h800000, 1'b0, '0},
    '{CMD_ACK,    24'h7FFFFF, 1'b0, '0},
    '{CMD_ACK,    24'h000001, 1'b0, '0},
    '{CMD_LOSS,   24'hFFFFFF, 1'b0, '0},
    '{CMD_UNUSED, 24'h555555, 1'b0, '0},
    '{CMD_ACK,    24'hAAAAAA, 1'b0, '0},
    '{CMD_SEND,   24'h000000, 1'b0, '0},
    '{CMD_ACK,    24'h0000FF, 1'b0, '0},
    '{CMD_LOSS,   24'h000000, 1'b0, '0},
    // acks with nothing in flight must not wrap the count
    '{CMD_ACK,    24'hFFFFFF, 1'b0, '0},
    '{CMD_ACK,    24'h000000, 1'b0, '0},
    '{CMD_SEND,   24'h000000, 1'b0, '0},
    '{CMD_UNUSED, 24'h000000, 1'b0, '0}
  };

  // clock, reset and block ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            cmd = CMD_SEND;
  logic [23:0]           rtt_sample_q8 = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  can_send;
  logic [15:0]           window_segments;
  logic [15:0]           outstanding;
  logic [23:0]           timeout_q8;
  logic [23:0]           smoothed_rtt_q8;
  logic                  avoidance_phase;

  // model copy of the registers
  logic [7:0]  alpha_q8;
  logic [7:0]  beta_q8;
  logic [23:0] rto_min;
  logic [23:0] rto_max;
  logic [15:0] cwnd_min;

  // model copy of the tracker state
  logic [31:0] cwnd_q16;
  logic [31:0] ssthresh_q16;
  logic [15:0] flight;
  logic [23:0] srtt;
  logic [23:0] rttvar;
  logic [23:0] rto;
  logic        rtt_seeded;
  logic        in_avoidance;

  // results still owed by the block, oldest first
  tracker_result_t pending_results [$];
  tracker_result_t observed;
  tracker_result_t oldest;
  int              mismatches = 0;

  // stall rates in percent, and the centre of the rtt spread
  int send_idle_pct = 12;
  int recv_idle_pct = 51;
  int rtt_base = 25600;

  congestion_window_rto_tracker i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .rtt_sample_q8   (rtt_sample_q8),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .can_send        (can_send),
    .window_segments (window_segments),
    .outstanding     (outstanding),
    .timeout_q8      (timeout_q8),
    .smoothed_rtt_q8 (smoothed_rtt_q8),
    .avoidance_phase (avoidance_phase)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic void reset_tracker();
    alpha_q8     = SRTT_GAIN_RESET;
    beta_q8      = RTTVAR_GAIN_RESET;
    rto_min      = RTO_FLOOR_RESET;
    rto_max      = RTO_CEILING_RESET;
    cwnd_min     = WINDOW_FLOOR_RESET;
    cwnd_q16     = WINDOW_RESET;
    ssthresh_q16 = THRESHOLD_RESET;
    flight       = '0;
    srtt         = '0;
    rttvar       = '0;
    rto          = TIMEOUT_RESET;
    rtt_seeded   = 1'b0;
    in_avoidance = 1'b0;
  endfunction

  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_SRTT_GAIN:    alpha_q8 = val[7:0];
      REG_RTTVAR_GAIN:  beta_q8  = val[7:0];
      REG_RTO_FLOOR:    rto_min  = val[23:0];
      REG_RTO_CEILING:  rto_max  = val[23:0];
      REG_WINDOW_FLOOR: cwnd_min = val[15:0];
      default: ;
    endcase
  endfunction

  // rfc 6298 style smoothing, variance first, then clamp of the timeout
  function automatic void update_rtt(input logic [23:0] sample);
    logic [23:0] gap;
    logic [39:0] mix;
    logic [26:0] span;
    if (!rtt_seeded) begin
      srtt       = sample;
      rttvar     = sample >> 1;
      rtt_seeded = 1'b1;
    end else begin
      gap    = (srtt >= sample) ? srtt - sample : sample - srtt;
      mix    = 40'(GAIN_ONE - beta_q8) * 40'(rttvar) + 40'(beta_q8) * 40'(gap);
      rttvar = mix[31:8];
      mix    = 40'(GAIN_ONE - alpha_q8) * 40'(srtt) + 40'(alpha_q8) * 40'(sample);
      srtt   = mix[31:8];
    end
    span = 27'(srtt) + 27'({rttvar, 2'b00});
    if (span < 27'(rto_min)) span = 27'(rto_min);
    if (span > 27'(rto_max)) span = 27'(rto_max);
    rto = span[23:0];
  endfunction

  // one segment per ack in slow start, 1/cwnd per ack in avoidance
  function automatic void grow_window();
    logic [33:0] incr;
    logic [33:0] total;
    if (!in_avoidance)
      incr = 34'h0_0001_0000;
    else if (cwnd_q16 == '0)
      incr = 34'h1_0000_0000;
    else
      incr = 34'(64'h1_0000_0000 / 64'(cwnd_q16));
    total    = 34'(cwnd_q16) + incr;
    cwnd_q16 = (total[33:32] != 2'b00) ? 32'hFFFF_FFFF : total[31:0];
    if (!in_avoidance && cwnd_q16 >= ssthresh_q16) in_avoidance = 1'b1;
  endfunction

  // applies one event and returns the values the block must report
  function automatic tracker_result_t track_event(input logic [1:0] op,
                                                 input logic [23:0] sample);
    logic [31:0]     floor_q16;
    tracker_result_t res;
    case (op)
      CMD_SEND: begin
        if (flight != 16'hFFFF) flight = flight + 16'd1;
      end
      CMD_ACK: begin
        if (flight != 16'd0) flight = flight - 16'd1;
        update_rtt(sample);
        grow_window();
      end
      CMD_LOSS: begin
        floor_q16    = {cwnd_min, 16'h0000};
        ssthresh_q16 = ((cwnd_q16 >> 1) < floor_q16) ? floor_q16 : cwnd_q16 >> 1;
        cwnd_q16     = floor_q16;
        in_avoidance = 1'b0;
      end
      default: ;
    endcase
    res.can_send        = flight < cwnd_q16[31:16];
    res.window_segments = cwnd_q16[31:16];
    res.outstanding     = flight;
    res.timeout_q8      = rto;
    res.smoothed_rtt_q8 = srtt;
    res.avoidance_phase = in_avoidance;
    return res;
  endfunction

  // ---------------------------------------------------------------- event side

  // offers one event item and books its expected result on acceptance;
  // valid stays high afterwards so the next item can follow without a gap
  task automatic offer_item(input logic [1:0] op, input logic [23:0] sample,
                            input logic typed, input tracker_result_t want);
    tracker_result_t forecast;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= op;
    rtt_sample_q8 <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    forecast = track_event(op, sample);
    pending_results.push_back(typed ? want : forecast);
  endtask

  // mostly jitter around the phase's typical rtt, plus extremes and raw bits
  function automatic logic [23:0] pick_rtt();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return 24'h000000;
    if (pick < 10) return 24'hFFFFFF;
    if (pick < 30) return 24'($urandom);
    return 24'(rtt_base - rtt_base / 4 + $urandom_range(rtt_base / 2));
  endfunction

  // reno-like traffic: send while the window allows, otherwise ack, with
  // some free mixing, occasional loss and the odd unused code
  task automatic random_burst(input int count);
    int         pick;
    logic [1:0] op;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 3)
        op = CMD_LOSS;
      else if (pick < 5)
        op = CMD_UNUSED;
      else if (pick < 75)
        op = (flight < cwnd_q16[31:16]) ? CMD_SEND : CMD_ACK;
      else
        op = $urandom_range(1) ? CMD_ACK : CMD_SEND;
      offer_item(op, pick_rtt(), 1'b0, '0);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    set_register(idx, val);
    @(posedge clk);
  endtask

  // drains the block, then rewrites all five registers
  task automatic configure(input logic [7:0] gain_a, input logic [7:0] gain_b,
                           input logic [23:0] lo, input logic [23:0] hi,
                           input logic [15:0] win_lo);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_SRTT_GAIN, CFG_DATA_W'(gain_a));
    write_reg(REG_RTTVAR_GAIN, CFG_DATA_W'(gain_b));
    write_reg(REG_RTO_FLOOR, lo);
    write_reg(REG_RTO_CEILING, hi);
    write_reg(REG_WINDOW_FLOOR, CFG_DATA_W'(win_lo));
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------- result side

  // outputs are read at the edge before the block updates them
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      observed = '{can_send, window_segments, outstanding, timeout_q8,
                   smoothed_rtt_q8, avoidance_phase};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: window=%0d outstanding=%0d",
                   observed.window_segments, observed.outstanding);
      end else begin
        oldest = pending_results.pop_front();
        if (observed !== oldest) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected can_send=%0d window=%0d outstanding=%0d",
                     oldest.can_send, oldest.window_segments, oldest.outstanding);
            $display("  timeout=%0h srtt=%0h phase=%0d",
                     oldest.timeout_q8, oldest.smoothed_rtt_q8, oldest.avoidance_phase);
            $display("  got can_send=%0d window=%0d outstanding=%0d",
                     observed.can_send, observed.window_segments, observed.outstanding);
            $display("  timeout=%0h srtt=%0h phase=%0d",
                     observed.timeout_q8, observed.smoothed_rtt_q8,
                     observed.avoidance_phase);
          end
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int k;
    reset_tracker();
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // register defaults, sender idles lightly, receiver stalls heavily
    foreach (DIRECTED_STEPS[i])
      offer_item(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].sample,
                 DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);

    // weakest and strongest gains, no timeout floor, window floor of one segment
    rtt_base = 25600;
    configure(8'd1, 8'd255, 24'h000000, 24'hFFFFFF, 16'd1);
    random_burst(320);

    // largest floors: timeout pinned high, window saturates at the top
    rtt_base = 24'h200000;
    configure(8'd255, 8'd1, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    random_burst(320);

    // stalls swap sides
    send_idle_pct = 51;
    recv_idle_pct = 12;

    // zero gains freeze the estimate, floor above ceiling, zero window floor
    rtt_base = 5000;
    configure(8'd0, 8'd0, 24'h100000, 24'h000100, 16'd0);
    random_burst(320);

    // a random but sane setting
    rtt_base = $urandom_range(256, 24'h100000);
    configure(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
              24'($urandom_range(0, 24'h020000)),
              24'($urandom_range(24'h020000, 24'hFFFFFF)),
              16'($urandom_range(1, 16)));
    random_burst(320);

    // no stalls at all from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // back to the reset values
    rtt_base = 12800;
    configure(SRTT_GAIN_RESET, RTTVAR_GAIN_RESET, RTO_FLOOR_RESET,
              RTO_CEILING_RESET, WINDOW_FLOOR_RESET);
    random_burst(320);

    // a closing run of sends, an ack, another send and a loss
    repeat (4) offer_item(CMD_SEND, 24'($urandom), 1'b0, '0);
    offer_item(CMD_ACK, pick_rtt(), 1'b0, '0);
    offer_item(CMD_SEND, 24'($urandom), 1'b0, '0);
    offer_item(CMD_LOSS, 24'($urandom), 1'b0, '0);

    in_valid <= 1'b0;
    for (k = 0; k < 10000 && pending_results.size() != 0; k++) @(posedge clk);
    // room for any stray result behind the last one
    repeat (40) @(posedge clk);
    mismatches += pending_results.size();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
